>>> design/position_jump_smoothing_gate_macros.svh
// assertion helpers for the checks in this block
`ifndef POSITION_JUMP_SMOOTHING_GATE_MACROS_SVH
`define POSITION_JUMP_SMOOTHING_GATE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PJSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PJSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pjsg_pkg.sv
`default_nettype none

package pjsg_pkg;

    localparam int DIST_W = 33;
    localparam int MS_W   = 16;
    localparam int PROD_W = 22;

    localparam logic [16:0] MS_PER_S    = 17'd1000;
    localparam logic [31:0] MAX_SEC_GAP = 32'd65;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEFAULT_INTERVAL = 2'd0,
        CFG_MAX_INTERVAL     = 2'd1,
        CFG_TRAVEL_MODE      = 2'd2,
        CFG_ROUTE_ACTIVE     = 2'd3
    } t_cfg_idx;

    // travel mode codes, anything else is drive
    localparam logic [1:0] MODE_WALK  = 2'd0;
    localparam logic [1:0] MODE_BIKE  = 2'd1;
    localparam logic [1:0] MODE_DRIVE = 2'd2;

    typedef struct packed {
        logic [MS_W-1:0] default_interval_ms;
        logic [MS_W-1:0] max_interval_ms;
        logic [1:0]      travel_mode;
        logic            route_active;
    } t_cfg;

    typedef struct packed {
        logic [4:0] base;
        logic [5:0] rate;
        logic [8:0] cap;
    } t_mode_lim;

    function automatic t_mode_lim mode_limits(input logic [1:0] mode, input logic route);
        t_mode_lim l;
        case (mode)
            MODE_WALK: begin
                l.base = 5'd8;
                l.rate = 6'd3;
                l.cap  = route ? 9'd36 : 9'd48;
            end
            MODE_BIKE: begin
                l.base = 5'd12;
                l.rate = 6'd10;
                l.cap  = route ? 9'd96 : 9'd128;
            end
            default: begin
                l.base = 5'd20;
                l.rate = 6'd45;
                l.cap  = route ? 9'd192 : 9'd256;
            end
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

>>> design/position_jump_smoothing_gate.sv
// Position jump smoothing gate. Each input item carries an old and a new world
// position plus fix timing; the block returns one result item per input with the
// approximate jump distance (max(|dx|,|dy|) + min/2, exact over 33 bits, zero when
// there was no previous fix) and an animate flag that is set when the distance is
// nonzero and within the travel-mode limit for the elapsed time. The block takes
// one item per cycle while o_in_stall is low. An item is held in the input
// register, and all the arithmetic runs between that register and the result
// register, which drives o_out_valid. The input stalls only when both registers
// hold items and the output is stalled. Configuration registers are written
// through the cfg port (always ready) and must only change while no item is
// in flight.
`default_nettype none

module position_jump_smoothing_gate
    import pjsg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_in_had_fix,
    input  wire logic signed [31:0]  i_in_old_x,
    input  wire logic signed [31:0]  i_in_old_y,
    input  wire logic signed [31:0]  i_in_new_x,
    input  wire logic signed [31:0]  i_in_new_y,
    input  wire logic signed [31:0]  i_in_old_stamp_ms,
    input  wire logic signed [31:0]  i_in_new_stamp_ms,
    input  wire logic [31:0]         i_in_old_received_s,
    input  wire logic [31:0]         i_in_now_s,

    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_out_animate,
    output logic [DIST_W-1:0]        o_out_jump_distance,

    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    `include "position_jump_smoothing_gate_macros.svh"

    t_cfg r_cfg;

    logic               r_v1;
    logic               r_had_fix;
    logic signed [31:0] r_old_x;
    logic signed [31:0] r_old_y;
    logic signed [31:0] r_new_x;
    logic signed [31:0] r_new_y;
    logic signed [31:0] r_old_stamp_ms;
    logic signed [31:0] r_new_stamp_ms;
    logic [31:0]        r_old_received_s;
    logic [31:0]        r_now_s;

    logic               r_v2;
    logic               r_animate;
    logic [DIST_W-1:0]  r_dist;

    logic               n_v1;
    logic               n_v2;
    logic               accept;
    logic               advance;
    logic [DIST_W-1:0]  dist_px;
    logic               animate;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_interval_ms <= 16'd1000;
            r_cfg.max_interval_ms     <= 16'd5000;
            r_cfg.travel_mode         <= MODE_DRIVE;
            r_cfg.route_active        <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEFAULT_INTERVAL: r_cfg.default_interval_ms <= i_cfg_data;
                CFG_MAX_INTERVAL:     r_cfg.max_interval_ms     <= i_cfg_data;
                CFG_TRAVEL_MODE:      r_cfg.travel_mode         <= i_cfg_data[1:0];
                CFG_ROUTE_ACTIVE:     r_cfg.route_active        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register moves on whenever the result register is free or draining
    assign advance    = r_v1 && !(r_v2 && i_out_stall);
    assign o_in_stall = r_v1 && r_v2 && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_v1 = r_v1;
        if (accept) begin
            n_v1 = 1'b1;
        end else if (advance) begin
            n_v1 = 1'b0;
        end
        n_v2 = r_v2;
        if (advance) begin
            n_v2 = 1'b1;
        end else if (!i_out_stall) begin
            n_v2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_had_fix        <= i_in_had_fix;
            r_old_x          <= i_in_old_x;
            r_old_y          <= i_in_old_y;
            r_new_x          <= i_in_new_x;
            r_new_y          <= i_in_new_y;
            r_old_stamp_ms   <= i_in_old_stamp_ms;
            r_new_stamp_ms   <= i_in_new_stamp_ms;
            r_old_received_s <= i_in_old_received_s;
            r_now_s          <= i_in_now_s;
        end
    end

    pjsg_dist u_dist (
        .i_old_x (r_old_x),
        .i_old_y (r_old_y),
        .i_new_x (r_new_x),
        .i_new_y (r_new_y),
        .o_dist  (dist_px)
    );

    pjsg_gate u_gate (
        .i_had_fix        (r_had_fix),
        .i_dist           (dist_px),
        .i_old_stamp_ms   (r_old_stamp_ms),
        .i_new_stamp_ms   (r_new_stamp_ms),
        .i_old_received_s (r_old_received_s),
        .i_now_s          (r_now_s),
        .i_cfg            (r_cfg),
        .o_animate        (animate)
    );

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_animate <= animate;
            r_dist    <= r_had_fix ? dist_px : '0;
        end
    end

    assign o_out_valid         = r_v2;
    assign o_out_animate       = r_animate;
    assign o_out_jump_distance = r_dist;

    `PJSG_ASSERT_NOW(a_anim_nonzero, i_clk, i_rst_n, o_out_valid && o_out_animate, o_out_jump_distance != '0, "animate with zero distance")
    `PJSG_ASSERT_NOW(a_anim_capped, i_clk, i_rst_n, o_out_valid && o_out_animate, o_out_jump_distance <= DIST_W'(256), "animate beyond largest cap")
    `PJSG_ASSERT_NEXT(a_advance_lands, i_clk, i_rst_n, advance, o_out_valid, "item lost between stages")

endmodule

`default_nettype wire

>>> design/pjsg_dist.sv
`default_nettype none

module pjsg_dist
    import pjsg_pkg::*;
(
    input  wire logic signed [31:0] i_old_x,
    input  wire logic signed [31:0] i_old_y,
    input  wire logic signed [31:0] i_new_x,
    input  wire logic signed [31:0] i_new_y,
    output logic [DIST_W-1:0]       o_dist
);

    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [32:0] major;
    logic [32:0] minor;

    // 33-bit differences never wrap; abs of the most negative still fits unsigned
    assign dx = {i_new_x[31], i_new_x} - {i_old_x[31], i_old_x};
    assign dy = {i_new_y[31], i_new_y} - {i_old_y[31], i_old_y};
    assign ax = dx[32] ? (33'd0 - dx) : dx;
    assign ay = dy[32] ? (33'd0 - dy) : dy;

    assign major  = (ax > ay) ? ax : ay;
    assign minor  = (ax > ay) ? ay : ax;
    assign o_dist = major + {1'b0, minor[32:1]};

endmodule

`default_nettype wire

>>> design/pjsg_gate.sv
`default_nettype none

module pjsg_gate
    import pjsg_pkg::*;
(
    input  wire logic                i_had_fix,
    input  wire logic [DIST_W-1:0]   i_dist,
    input  wire logic signed [31:0]  i_old_stamp_ms,
    input  wire logic signed [31:0]  i_new_stamp_ms,
    input  wire logic [31:0]         i_old_received_s,
    input  wire logic [31:0]         i_now_s,
    input  wire t_cfg                i_cfg,
    output logic                     o_animate
);

    logic              stamp_ok;
    logic [31:0]       stamp_diff;
    logic [MS_W-1:0]   e_stamp;
    logic              sec_ok;
    logic [31:0]       sec_diff;
    logic [16:0]       sec_ms;
    logic [MS_W-1:0]   e_sec;
    logic [MS_W-1:0]   e_def;
    logic [MS_W-1:0]   elapsed;
    t_mode_lim         lim;
    logic [PROD_W-1:0] rate_e;
    logic              in_cap;
    logic              above_base;
    logic [8:0]        excess;
    logic [PROD_W-1:0] excess_ms;

    assign stamp_ok   = !i_old_stamp_ms[31] && (i_new_stamp_ms >= i_old_stamp_ms);
    assign stamp_diff = i_new_stamp_ms - i_old_stamp_ms;
    assign e_stamp    = (stamp_diff > {16'd0, i_cfg.max_interval_ms})
                      ? i_cfg.max_interval_ms : stamp_diff[MS_W-1:0];

    // more than 65 s always exceeds any 16-bit clamp
    assign sec_ok   = (i_old_received_s != 32'd0) && (i_now_s > i_old_received_s);
    assign sec_diff = i_now_s - i_old_received_s;
    assign sec_ms   = {10'd0, sec_diff[6:0]} * MS_PER_S;
    assign e_sec    = ((sec_diff > MAX_SEC_GAP) || (sec_ms > {1'b0, i_cfg.max_interval_ms}))
                    ? i_cfg.max_interval_ms : sec_ms[MS_W-1:0];

    assign e_def = (i_cfg.default_interval_ms > i_cfg.max_interval_ms)
                 ? i_cfg.max_interval_ms : i_cfg.default_interval_ms;

    assign elapsed = stamp_ok ? e_stamp : (sec_ok ? e_sec : e_def);

    assign lim    = mode_limits(i_cfg.travel_mode, i_cfg.route_active);
    assign rate_e = PROD_W'(elapsed) * PROD_W'(lim.rate);

    // dist <= base + floor(rate*e/1000) is the same as (dist-base)*1000 <= rate*e
    assign in_cap     = i_dist <= DIST_W'(lim.cap);
    assign above_base = i_dist > DIST_W'(lim.base);
    assign excess     = i_dist[8:0] - {4'd0, lim.base};
    assign excess_ms  = PROD_W'(excess) * PROD_W'(MS_PER_S);

    assign o_animate = i_had_fix && (i_dist != '0) && in_cap
                    && (!above_base || (excess_ms <= rate_e));

endmodule

`default_nettype wire

>>> tb/sv/position_jump_smoothing_gate_tb.sv
`default_nettype none

module position_jump_smoothing_gate_tb
    import pjsg_pkg::*;
();

    localparam int CYCLE_LIMIT       = 400000;
    localparam int ITEMS_PER_SETTING = 283;
    localparam int HOLD_CYCLES       = 300;
    localparam int TAIL_CYCLES       = 10;

    // travel mode code not named in the package
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        logic        had_fix;
        logic [31:0] old_x;
        logic [31:0] old_y;
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] old_stamp_ms;
        logic [31:0] new_stamp_ms;
        logic [31:0] old_received_s;
        logic [31:0] now_s;
    } t_update;

    typedef struct {
        logic              animate;
        logic [DIST_W-1:0] jump_len;
    } t_verdict;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    cfg_idx;
        logic [15:0] cfg_val;
        t_update     upd;
        bit          has_exp;
        t_verdict    exp;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_in_had_fix = 1'b0;
    logic signed [31:0]  i_in_old_x = '0;
    logic signed [31:0]  i_in_old_y = '0;
    logic signed [31:0]  i_in_new_x = '0;
    logic signed [31:0]  i_in_new_y = '0;
    logic signed [31:0]  i_in_old_stamp_ms = '0;
    logic signed [31:0]  i_in_new_stamp_ms = '0;
    logic [31:0]         i_in_old_received_s = '0;
    logic [31:0]         i_in_now_s = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_out_animate;
    logic [DIST_W-1:0]   o_out_jump_distance;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [15:0]         i_cfg_data = '0;

    t_verdict    awaited_verdicts[$];
    t_cfg        cfg_now;
    int          mismatches = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          burst_left = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int          hold_left = 0;
    bit          offering = 1'b0;
    int unsigned cycles = 0;

    position_jump_smoothing_gate DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_had_fix        (i_in_had_fix),
        .i_in_old_x          (i_in_old_x),
        .i_in_old_y          (i_in_old_y),
        .i_in_new_x          (i_in_new_x),
        .i_in_new_y          (i_in_new_y),
        .i_in_old_stamp_ms   (i_in_old_stamp_ms),
        .i_in_new_stamp_ms   (i_in_new_stamp_ms),
        .i_in_old_received_s (i_in_old_received_s),
        .i_in_now_s          (i_in_now_s),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_animate       (o_out_animate),
        .o_out_jump_distance (o_out_jump_distance),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_verdict judge_jump(input t_update u);
        longint   ax, ay, major_d, minor_d, span_px, elapsed, base, rate, cap, lim;
        t_verdict v;
        v.animate  = 1'b0;
        v.jump_len = '0;
        if (!u.had_fix)
            return v;
        ax = longint'($signed(u.new_x)) - longint'($signed(u.old_x));
        ay = longint'($signed(u.new_y)) - longint'($signed(u.old_y));
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        major_d = (ax > ay) ? ax : ay;
        minor_d = (ax > ay) ? ay : ax;
        span_px = major_d + minor_d / 2;
        v.jump_len = span_px[DIST_W-1:0];
        if (span_px == 0)
            return v;

        if (!u.old_stamp_ms[31] && $signed(u.new_stamp_ms) >= $signed(u.old_stamp_ms))
            elapsed = longint'($signed(u.new_stamp_ms)) - longint'($signed(u.old_stamp_ms));
        else if (u.old_received_s != 0 && u.now_s > u.old_received_s)
            elapsed = (longint'(u.now_s) - longint'(u.old_received_s)) * 1000;
        else
            elapsed = longint'(cfg_now.default_interval_ms);
        if (elapsed > longint'(cfg_now.max_interval_ms))
            elapsed = longint'(cfg_now.max_interval_ms);

        case (cfg_now.travel_mode)
            MODE_WALK: begin
                base = 8;
                rate = 3;
                cap  = cfg_now.route_active ? 36 : 48;
            end
            MODE_BIKE: begin
                base = 12;
                rate = 10;
                cap  = cfg_now.route_active ? 96 : 128;
            end
            default: begin
                base = 20;
                rate = 45;
                cap  = cfg_now.route_active ? 192 : 256;
            end
        endcase
        lim = base + (rate * elapsed) / 1000;
        if (lim > cap) lim = cap;
        v.animate = (span_px <= lim);
        return v;
    endfunction

    function automatic t_update mk_upd(input logic had, input logic [31:0] ox,
                                       input logic [31:0] oy, input logic [31:0] nx,
                                       input logic [31:0] ny, input logic [31:0] os,
                                       input logic [31:0] ns, input logic [31:0] orx,
                                       input logic [31:0] nw);
        t_update u;
        u.had_fix        = had;
        u.old_x          = ox;
        u.old_y          = oy;
        u.new_x          = nx;
        u.new_y          = ny;
        u.old_stamp_ms   = os;
        u.new_stamp_ms   = ns;
        u.old_received_s = orx;
        u.now_s          = nw;
        return u;
    endfunction

    function automatic t_row mk_row(input t_update u, input bit has_exp,
                                    input logic anim, input logic [DIST_W-1:0] len);
        t_row r;
        r.kind         = ROW_ITEM;
        r.cfg_idx      = CFG_DEFAULT_INTERVAL;
        r.cfg_val      = '0;
        r.upd          = u;
        r.has_exp      = has_exp;
        r.exp.animate  = anim;
        r.exp.jump_len = len;
        return r;
    endfunction

    function automatic t_row mk_cfg_row(input t_cfg_idx idx, input logic [15:0] val);
        t_row r;
        r         = mk_row(mk_upd(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0);
        r.kind    = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic t_update make_update();
        t_update     u;
        int unsigned pick, tpick, span;
        pick = $urandom_range(0, 9);
        u = mk_upd($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        if (pick >= 2) begin
            // well-formed update: small jump, plausible timing
            u.had_fix = 1'b1;
            span = $urandom_range(0, 1) ? 300 : 40;
            u.new_x = u.old_x + $urandom_range(0, 2 * span) - span;
            u.new_y = u.old_y + $urandom_range(0, 2 * span) - span;
            tpick = $urandom_range(0, 5);
            case (tpick)
                0, 1: begin
                    u.old_stamp_ms = $urandom_range(0, 32'h7FFFFFFF);
                    u.new_stamp_ms = u.old_stamp_ms + $urandom_range(0, 7000);
                end
                2: begin
                    u.old_stamp_ms   = $urandom | 32'h80000000;
                    u.now_s          = u.old_received_s + $urandom_range(0, 8);
                end
                3: begin
                    u.old_stamp_ms   = $urandom_range(1, 32'h7FFFFFFF);
                    u.new_stamp_ms   = u.old_stamp_ms - $urandom_range(1, 5000);
                    u.now_s          = u.old_received_s + $urandom_range(0, 8);
                end
                4: begin
                    u.old_stamp_ms   = $urandom | 32'h80000000;
                    u.old_received_s = '0;
                    u.now_s          = $urandom_range(0, 8);
                end
                default: ;
            endcase
        end
        return u;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic offer_update(input t_update u, input bit use_given, input t_verdict given);
        while (burst_left == 0 && $urandom_range(0, 99) < snd_idle) begin
            if (offering) begin
                i_in_valid <= 1'b0;
                offering = 1'b0;
            end
            @(posedge i_clk);
        end
        i_in_had_fix        <= u.had_fix;
        i_in_old_x          <= u.old_x;
        i_in_old_y          <= u.old_y;
        i_in_new_x          <= u.new_x;
        i_in_new_y          <= u.new_y;
        i_in_old_stamp_ms   <= u.old_stamp_ms;
        i_in_new_stamp_ms   <= u.new_stamp_ms;
        i_in_old_received_s <= u.old_received_s;
        i_in_now_s          <= u.now_s;
        i_in_valid          <= 1'b1;
        offering = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        awaited_verdicts.push_back(use_given ? given : judge_jump(u));
    endtask

    task automatic drain_results();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (awaited_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEFAULT_INTERVAL: cfg_now.default_interval_ms = val;
            CFG_MAX_INTERVAL:     cfg_now.max_interval_ms     = val;
            CFG_TRAVEL_MODE:      cfg_now.travel_mode         = val[1:0];
            CFG_ROUTE_ACTIVE:     cfg_now.route_active        = val[0];
            default: ;
        endcase
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    // receiver side: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen   <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_verdicts.size() == 0) begin
                report_mismatch("result item with nothing pending");
            end else begin
                want = awaited_verdicts.pop_front();
                if (o_out_animate !== want.animate)
                    report_mismatch($sformatf("animate %b, want %b",
                                              o_out_animate, want.animate));
                if (o_out_jump_distance !== want.jump_len)
                    report_mismatch($sformatf("jump_distance %0d, want %0d",
                                              o_out_jump_distance, want.jump_len));
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("position_jump_smoothing_gate test failed");
        $finish;
    end

    initial begin : stimulus
        t_row        dir_rows[$];
        t_verdict    blank;
        logic [15:0] def_v, max_v, junk;
        logic [1:0]  mode_v;
        logic        route_v;
        int          ph, c, k, i;

        blank.animate  = 1'b0;
        blank.jump_len = '0;
        cfg_now.default_interval_ms = 16'd1000;
        cfg_now.max_interval_ms     = 16'd5000;
        cfg_now.travel_mode         = MODE_DRIVE;
        cfg_now.route_active        = 1'b0;

        // reset configuration: drive, no route, 1000 ms default, 5000 ms max
        dir_rows.push_back(mk_row(mk_upd(0, 32'h7FFFFFFF, 32'h80000000, 0, 5, 0, 10, 1, 2),
                                  1, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(0, '1, '1, '1, '1, '1, '1, '1, '1), 1, 0, 0));
        // zero distance
        dir_rows.push_back(mk_row(mk_upd(1, 100, 100, 100, 100, 0, 1000, 0, 0), 1, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                         32'h7FFFFFFF, '1, 0, '1, '1), 1, 0, 0));
        // widest differences, no wrap
        dir_rows.push_back(mk_row(mk_upd(1, 32'h80000000, 0, 32'h7FFFFFFF, 0, 0, 1000, 0, 0),
                                  1, 0, 33'h0FFFFFFFF));
        dir_rows.push_back(mk_row(mk_upd(1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                         32'h80000000, 0, 1000, 0, 0),
                                  1, 0, 33'd6442450942));
        // usable stamps, right at the limit and one past
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 65, 0, 0, 1000, 0, 0), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 66, 0, 0, 1000, 0, 0), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, -10, -20, -50, 30, 0, 1000, 0, 0), 0, 0, 0));
        // unknown old stamp, seconds used
        dir_rows.push_back(mk_row(mk_upd(1, 500, 500, 600, 500, '1, 5000, 10, 12), 0, 0, 0));
        // stamps out of order, no arrival second
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 0, -60, 5000, 4000, 0, 7), 0, 0, 0));
        // same second, then clock went back
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 65, 1, 32'h80000000, 0, 9, 9), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 7, 7, 7, 73, 200, 100, '1, 0), 0, 0, 0));
        // elapsed beyond the maximum, from seconds and from stamps
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 245, 0, -1, 0, 1, '1), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 246, 0, 0, 32'h7FFFFFFF, 0, 0), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 32'h7FFFFF00, 0, 32'h7FFFFFFF, 0, 32'h80000000,
                                         32'h7FFFFFFF, 0, 0), 0, 0, 0));
        // spare mode code acts as drive, route cap
        dir_rows.push_back(mk_cfg_row(CFG_TRAVEL_MODE, {14'd0, MODE_SPARE}));
        dir_rows.push_back(mk_cfg_row(CFG_ROUTE_ACTIVE, 16'd1));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 0, 192, 0, 5000, 0, 0), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 0, 193, 0, 5000, 0, 0), 0, 0, 0));
        // walk with a zero default interval
        dir_rows.push_back(mk_cfg_row(CFG_TRAVEL_MODE, {14'd0, MODE_WALK}));
        dir_rows.push_back(mk_cfg_row(CFG_DEFAULT_INTERVAL, 16'd0));
        dir_rows.push_back(mk_cfg_row(CFG_MAX_INTERVAL, 16'hFFFF));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 8, 0, -1, 0, 0, 0), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 9, 0, -1, 0, 0, 0), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 36, 0, 0, 100000, 0, 0), 0, 0, 0));
        // bike with a zero maximum, then the widest default
        dir_rows.push_back(mk_cfg_row(CFG_TRAVEL_MODE, {14'd0, MODE_BIKE}));
        dir_rows.push_back(mk_cfg_row(CFG_ROUTE_ACTIVE, 16'd0));
        dir_rows.push_back(mk_cfg_row(CFG_MAX_INTERVAL, 16'd0));
        dir_rows.push_back(mk_cfg_row(CFG_DEFAULT_INTERVAL, 16'hFFFF));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 12, 0, -1, 0, 5, 100), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 13, 0, -1, 0, 5, 100), 0, 0, 0));
        dir_rows.push_back(mk_cfg_row(CFG_MAX_INTERVAL, 16'hFFFF));
        dir_rows.push_back(mk_row(mk_upd(1, 0, 0, 128, 0, -1, 0, 0, 0), 0, 0, 0));
        dir_rows.push_back(mk_row(mk_upd(1, 3, 3, 0, 0, 0, 0, 0, 0), 0, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 29;
        rcv_idle = 58;
        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_CFG) begin
                if (n == 0 || dir_rows[n-1].kind != ROW_CFG)
                    drain_results();
                write_reg(dir_rows[n].cfg_idx, dir_rows[n].cfg_val,
                          n + 1 == dir_rows.size() || dir_rows[n+1].kind != ROW_CFG);
            end else begin
                offer_update(dir_rows[n].upd, dir_rows[n].has_exp, dir_rows[n].exp);
            end
        end

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin snd_idle = 29; rcv_idle = 58; end
                1: begin snd_idle = 58; rcv_idle = 29; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            for (c = 0; c < 2; c++) begin
                k = ph * 2 + c;
                if (k == 0) begin
                    def_v = 16'd0; max_v = 16'd0; mode_v = MODE_WALK; route_v = 1'b0;
                end else if (k == 1) begin
                    def_v = 16'hFFFF; max_v = 16'hFFFF; mode_v = MODE_SPARE; route_v = 1'b1;
                end else begin
                    def_v   = 16'($urandom_range(0, 16'hFFFF));
                    max_v   = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'hFFFF))
                                                   : 16'($urandom_range(0, 8000));
                    mode_v  = 2'($urandom_range(0, 3));
                    route_v = 1'($urandom_range(0, 1));
                end
                junk = 16'($urandom);
                drain_results();
                write_reg(CFG_DEFAULT_INTERVAL, def_v, 1'b0);
                write_reg(CFG_MAX_INTERVAL, max_v, 1'b0);
                write_reg(CFG_TRAVEL_MODE, {junk[15:2], mode_v}, 1'b0);
                write_reg(CFG_ROUTE_ACTIVE, {junk[15:1], route_v}, 1'b1);
                for (i = 0; i < ITEMS_PER_SETTING; i++) begin
                    // long receiver hold-off while items keep coming back to back
                    if (k == 0 && i == 60) begin
                        hold_reqs++;
                        burst_left = 60;
                    end
                    if (k == 0 && i == 160)
                        drain_results();
                    offer_update(make_update(), 1'b0, blank);
                    if (burst_left != 0)
                        burst_left--;
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("position_jump_smoothing_gate test passed");
        else
            $display("position_jump_smoothing_gate test failed");
        $finish;
    end

endmodule

`default_nettype wire
